FILE: hw/rtl/xcsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcsf_pkg: shared types and constants of the XOR checksum sentence framer
// Character codes, emit step encoding and the descriptor that carries one
// accepted payload byte from the input stage to the character emitter.
// ----------------------------------------------------------------------------
package xcsf_pkg;

   typedef logic [7:0] char_type;

   localparam char_type ASCII_DOLLAR  = 8'h24;
   localparam char_type ASCII_CR      = 8'h0D;
   localparam char_type ASCII_LF      = 8'h0A;
   localparam char_type HEX_DIGIT_OFS = 8'd48;  // '0' for nibbles 0..9
   localparam char_type HEX_ALPHA_OFS = 8'd55;  // 'A' - 10 for nibbles 10..15
   localparam logic [3:0] HEX_DIGIT_LIMIT = 4'd10;

   // One character slot of a sentence, one-hot.
   typedef enum logic [5:0] {
      STEP_DOLLAR = 6'b000001,
      STEP_DATA   = 6'b000010,
      STEP_HI     = 6'b000100,
      STEP_LO     = 6'b001000,
      STEP_CR     = 6'b010000,
      STEP_LF     = 6'b100000
   } step_type;

   // Work for one payload byte: optional leading '$', the byte itself and,
   // when the byte closes the sentence, the checksum trailer.
   typedef struct packed {
      logic     lead;
      logic     close;
      char_type data;
      char_type csum;
   } desc_type;

   function automatic char_type nibble_to_hex(input logic [3:0] nib);
      char_type wide_nib;
      wide_nib = {4'b0000, nib};
      return (nib < HEX_DIGIT_LIMIT) ? (wide_nib + HEX_DIGIT_OFS)
                                     : (wide_nib + HEX_ALPHA_OFS);
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/xcsf_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcsf_req_if: payload byte channel
// Valid/ready channel carrying one message byte and its end-of-message flag.
// ----------------------------------------------------------------------------
interface xcsf_req_if import xcsf_pkg::*;;
   logic     valid;
   logic     ready;
   char_type msg_byte;
   logic     end_of_msg;

   modport source (output valid, output msg_byte, output end_of_msg, input ready);
   modport sink   (input valid, input msg_byte, input end_of_msg, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/xcsf_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcsf_rsp_if: framed character channel
// Valid/ready channel carrying one output character and its marker flags.
// ----------------------------------------------------------------------------
interface xcsf_rsp_if import xcsf_pkg::*;;
   logic     valid;
   logic     ready;
   char_type out_byte;
   logic     last_of_run;
   logic     frame_end;

   modport source (output valid, output out_byte, output last_of_run, output frame_end,
                   input ready);
   modport sink   (input valid, input out_byte, input last_of_run, input frame_end,
                   output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/xcsf_calc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcsf_calc: input stage
// Registers each accepted byte, tracks the open sentence and running XOR,
// and hands a descriptor with the finished checksum to the emitter.
// ----------------------------------------------------------------------------
module xcsf_calc import xcsf_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   xcsf_req_if.sink   req_ch,
   output desc_type   desc,
   output logic       desc_valid,
   input  wire logic  desc_take
);

   logic     in_frame_ff, in_frame_in;
   char_type running_xor_ff, running_xor_in;
   logic     desc_valid_ff, desc_valid_in;
   desc_type desc_ff, desc_in;
   logic     req_accept;
   char_type xor_sum;

   assign req_ch.ready = !desc_valid_ff || desc_take;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // A new sentence starts from a zero checksum.
   assign xor_sum = (in_frame_ff ? running_xor_ff : '0) ^ req_ch.msg_byte;

   always_comb begin
      in_frame_in    = in_frame_ff;
      running_xor_in = running_xor_ff;
      desc_valid_in  = desc_valid_ff && !desc_take;
      desc_in        = desc_ff;
      if (req_accept) begin
         in_frame_in    = !req_ch.end_of_msg;
         running_xor_in = req_ch.end_of_msg ? '0 : xor_sum;
         desc_valid_in  = 1'b1;
         desc_in.lead   = !in_frame_ff;
         desc_in.close  = req_ch.end_of_msg;
         desc_in.data   = req_ch.msg_byte;
         desc_in.csum   = xor_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         running_xor_ff <= '0;
         desc_valid_ff  <= 1'b0;
      end else begin
         in_frame_ff    <= in_frame_in;
         running_xor_ff <= running_xor_in;
         desc_valid_ff  <= desc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

   assign desc       = desc_ff;
   assign desc_valid = desc_valid_ff;

`ifndef SYNTHESIS
   a_close_clears_state: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_ch.end_of_msg) |=> (!in_frame_ff && running_xor_ff == '0))
      else $error("sentence state not cleared after closing byte");

   a_lead_when_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (desc_ff.lead == !$past(in_frame_ff)))
      else $error("leading dollar flag disagrees with sentence state");

   a_idle_xor_zero: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (running_xor_ff == '0))
      else $error("running checksum nonzero outside a sentence");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/xcsf_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcsf_emit: character emitter
// Holds one descriptor and steps through its characters, one per transfer.
// ----------------------------------------------------------------------------
module xcsf_emit import xcsf_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire desc_type desc,
   input  wire logic     desc_valid,
   output logic          desc_take,
   xcsf_rsp_if.source    rsp_ch
);

   logic     emit_valid_ff, emit_valid_in;
   step_type step_ff, step_in;
   desc_type cur_ff, cur_in;
   logic     last_char;
   logic     rsp_xfer;
   step_type step_next;
   char_type out_char;

   assign last_char = (step_ff == STEP_LF) || ((step_ff == STEP_DATA) && !cur_ff.close);
   assign rsp_xfer  = emit_valid_ff && rsp_ch.ready;
   assign desc_take = !emit_valid_ff || (rsp_ch.ready && last_char);

   always_comb begin
      unique case (step_ff)
         STEP_DOLLAR: begin out_char = ASCII_DOLLAR;                  step_next = STEP_DATA; end
         STEP_DATA:   begin out_char = cur_ff.data;                   step_next = STEP_HI;   end
         STEP_HI:     begin out_char = nibble_to_hex(cur_ff.csum[7:4]); step_next = STEP_LO; end
         STEP_LO:     begin out_char = nibble_to_hex(cur_ff.csum[3:0]); step_next = STEP_CR; end
         STEP_CR:     begin out_char = ASCII_CR;                      step_next = STEP_LF;   end
         STEP_LF:     begin out_char = ASCII_LF;                      step_next = STEP_LF;   end
         default:     begin out_char = ASCII_LF;                      step_next = STEP_LF;   end
      endcase
   end

   always_comb begin
      emit_valid_in = emit_valid_ff;
      step_in       = step_ff;
      cur_in        = cur_ff;
      priority if (desc_take) begin
         // load the next descriptor, or go empty
         emit_valid_in = desc_valid;
         step_in       = desc.lead ? STEP_DOLLAR : STEP_DATA;
         cur_in        = desc;
      end else if (rsp_xfer) begin
         step_in = step_next;
      end else begin
         // hold the current character
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_valid_ff <= 1'b0;
         step_ff       <= STEP_DATA;
      end else begin
         emit_valid_ff <= emit_valid_in;
         step_ff       <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_ch.valid       = emit_valid_ff;
   assign rsp_ch.out_byte    = out_char;
   assign rsp_ch.last_of_run = last_char;
   assign rsp_ch.frame_end   = (step_ff == STEP_LF);

`ifndef SYNTHESIS
   a_lf_only_on_close: assert property (@(posedge clock) disable iff (reset)
      (emit_valid_ff && step_ff == STEP_LF) |-> cur_ff.close)
      else $error("closing LF emitted for a byte that does not close");

   a_dollar_only_on_lead: assert property (@(posedge clock) disable iff (reset)
      (emit_valid_ff && step_ff == STEP_DOLLAR) |-> cur_ff.lead)
      else $error("dollar emitted for a byte inside a sentence");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !last_char) |=> (emit_valid_ff && step_ff == $past(step_next)))
      else $error("character run broken before its last character");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/xor_checksum_sentence_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xor_checksum_sentence_framer: XOR checksum sentence framer, top level
// Frames payload bytes into '$'-led sentences closed by a hex checksum,
// CR and LF.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one payload byte per transfer plus end_of_msg on the last
//   byte of a message. rsp_ch carries one framed character per transfer.
//   Each payload byte yields one to six characters: a '$' before the first
//   byte of a sentence, the byte itself and, after the last byte, the XOR of
//   all sentence bytes as two uppercase hex digits, CR and LF. last_of_run
//   marks the final character of a byte's run, frame_end marks the LF.
// Path: the first character of a byte is offered from the emitter register,
//   after the byte has passed the input register.
// Throughput: one character per cycle while rsp_ch.ready is high; bytes
//   inside a sentence then stream at one per cycle. This rate is set by
//   the emitter's one-character-per-cycle port.
// Reset: synchronous; no sentence open, checksum zero, both stages empty.
// Stall: while rsp_ch.ready is low the current character holds, and the
//   input register still takes one byte, after which req_ch.ready drops.
// ----------------------------------------------------------------------------
module xor_checksum_sentence_framer import xcsf_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   xcsf_req_if.sink   req_ch,
   xcsf_rsp_if.source rsp_ch
);

   desc_type desc;       // registered byte with its framing decisions
   logic     desc_valid; // input register holds a byte
   logic     desc_take;  // emitter moves the byte on this cycle

   // Input stage: sentence state, running checksum, byte register.
   xcsf_calc u_calc (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .desc       (desc),
      .desc_valid (desc_valid),
      .desc_take  (desc_take)
   );

   // Output stage: walk the characters of one byte, one per transfer.
   xcsf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .desc       (desc),
      .desc_valid (desc_valid),
      .desc_take  (desc_take),
      .rsp_ch     (rsp_ch)
   );

`ifndef SYNTHESIS
   a_frame_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.frame_end) |-> rsp_ch.last_of_run)
      else $error("frame end without end of run");

   a_frame_end_is_lf: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.frame_end) |-> (rsp_ch.out_byte == ASCII_LF))
      else $error("frame end on a character other than LF");

   a_no_take_while_empty_fed: assert property (@(posedge clock) disable iff (reset)
      (!rsp_ch.valid) |-> desc_take)
      else $error("empty emitter refuses the next byte");
`endif

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the XOR checksum sentence framer
// Feeds payload bytes on the request channel and compares every framed
// character on the response channel against an in-bench prediction of the
// sentence: leading '$', payload, two uppercase hex checksum digits, CR, LF.
// A short table of directed bytes runs first, then random sentences of mixed
// length, with random gaps and backpressure on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import xcsf_pkg::*;

   // One framed character as it should appear on the response channel.
   typedef struct packed {
      char_type ch;
      logic     run_end;
      logic     lf_end;
   } framed_char_type;

   // One row of the directed table. Rows with typed set are single-byte
   // sentences sent while idle; their checksum digits are written in by hand.
   typedef struct packed {
      char_type b;
      logic     eom;
      logic     typed;
      char_type hi;
      char_type lo;
   } stim_row_type;

   localparam int       RANDOM_BYTES = 456;
   localparam int       IDLE_PCT     = 17;
   localparam int       DRAIN_CYCLES = 16;
   localparam char_type ASCII_STAR   = 8'h2A;
   localparam string    HEX_CHARS    = "0123456789ABCDEF";

   // Payload bytes that look like framing characters.
   localparam char_type FRAMING_CHARS [4] = '{ASCII_DOLLAR, ASCII_CR, ASCII_LF, ASCII_STAR};

   localparam stim_row_type DIRECTED [22] = '{
      // single-byte sentences: extremes, framing characters, hex digit edges
      '{8'h00, 1'b1, 1'b1, "0", "0"},
      '{8'hFF, 1'b1, 1'b1, "F", "F"},
      '{8'h0A, 1'b1, 1'b1, "0", "A"},
      '{8'h24, 1'b1, 1'b1, "2", "4"},
      '{8'h0D, 1'b1, 1'b1, "0", "D"},
      '{8'h09, 1'b1, 1'b1, "0", "9"},
      '{8'h9F, 1'b1, 1'b1, "9", "F"},
      '{8'hA0, 1'b1, 1'b1, "A", "0"},
      // framing characters inside a longer sentence
      '{8'h24, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h0D, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h0A, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hFF, 1'b1, 1'b0, 8'h00, 8'h00},
      // bytes that cancel to a zero checksum
      '{8'h5A, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h5A, 1'b1, 1'b0, 8'h00, 8'h00},
      // walking one through every bit
      '{8'h01, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h02, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h04, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h08, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h10, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h40, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h80, 1'b1, 1'b0, 8'h00, 8'h00}
   };

   logic clock = 1'b0;
   logic reset;
   logic steady_flow = 1'b0;  // suppress idling on both sides

   xcsf_req_if req_ch ();
   xcsf_rsp_if rsp_ch ();

   xor_checksum_sentence_framer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predicted sentence state and the characters still owed by the block.
   logic            open_sentence = 1'b0;
   char_type        sentence_xor  = '0;
   framed_char_type pending_chars [$];

   int error_count      = 0;
   int bytes_sent       = 0;
   int sentences_closed = 0;
   int chars_checked    = 0;

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic char_type hex_char(input logic [3:0] nib);
      return char_type'(HEX_CHARS[nib]);
   endfunction

   function automatic void push_char(input char_type ch, input logic run_end,
                                     input logic lf_end);
      framed_char_type c;
      c.ch      = ch;
      c.run_end = run_end;
      c.lf_end  = lf_end;
      pending_chars = {pending_chars, c};
   endfunction

   // Advance the predicted sentence by one payload byte. With record set,
   // queue the characters that byte should produce.
   function automatic void frame_byte(input char_type b, input logic eom, input bit record);
      char_type sum;
      if (!open_sentence) begin
         if (record) push_char(ASCII_DOLLAR, 1'b0, 1'b0);
         open_sentence = 1'b1;
         sentence_xor  = '0;
      end
      sum = sentence_xor ^ b;
      if (record) push_char(b, !eom, 1'b0);
      if (eom) begin
         if (record) begin
            push_char(hex_char(sum[7:4]), 1'b0, 1'b0);
            push_char(hex_char(sum[3:0]), 1'b0, 1'b0);
            push_char(ASCII_CR, 1'b0, 1'b0);
            push_char(ASCII_LF, 1'b1, 1'b1);
         end
         open_sentence = 1'b0;
         sentence_xor  = '0;
         sentences_closed++;
      end else begin
         sentence_xor = sum;
      end
   endfunction

   // Offer one byte, wait for its transfer, then predict its characters.
   // Valid stays high between back-to-back bytes; a gap drops it first.
   task automatic send_byte(input char_type b, input logic eom, input bit record);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.msg_byte   <= b;
      req_ch.end_of_msg <= eom;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
      frame_byte(b, eom, record);
   endtask

   // Drop valid and hold until every predicted character has been seen.
   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_chars.size() != 0);
   endtask

   // Request side: reset, directed table, random sentences, drain, verdict.
   initial begin : req_side
      int       len;
      int       sent_random;
      char_type b;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.msg_byte   <= '0;
      req_ch.end_of_msg <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Typed rows are single-byte sentences from idle: '$', byte, two
      // checksum digits, CR, LF. The predictor still advances, silently.
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].typed) begin
            push_char(ASCII_DOLLAR, 1'b0, 1'b0);
            push_char(DIRECTED[i].b, 1'b0, 1'b0);
            push_char(DIRECTED[i].hi, 1'b0, 1'b0);
            push_char(DIRECTED[i].lo, 1'b0, 1'b0);
            push_char(ASCII_CR, 1'b0, 1'b0);
            push_char(ASCII_LF, 1'b1, 1'b1);
            send_byte(DIRECTED[i].b, 1'b1, 1'b0);
         end else begin
            send_byte(DIRECTED[i].b, DIRECTED[i].eom, 1'b1);
         end
      end
      hold_until_drained();

      // Random sentences: mostly short, some long; payload now and then
      // carries framing characters. Finish the sentence in progress.
      sent_random = 0;
      while (sent_random < RANDOM_BYTES) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(7) == 0) b = FRAMING_CHARS[$urandom_range(3)];
            else b = char_type'($urandom_range(255));
            // one full pause mid-run, possibly mid-sentence
            if (sent_random == RANDOM_BYTES / 4) hold_until_drained();
            steady_flow <= (sent_random >= 220 && sent_random < 320);
            send_byte(b, k == len - 1, 1'b1);
            sent_random++;
         end
      end
      steady_flow <= 1'b0;
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d payload bytes in %0d sentences, %0d characters checked",
               bytes_sent, sentences_closed, chars_checked);
      $display("directed extremes, framing bytes in payload, zero and 0xFF checksums, "
               , "mid-sentence pause and a stretch with no idling");
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Response side: random backpressure, check each transfer in order.
   initial begin : rsp_side
      framed_char_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected character 8'h%02h", rsp_ch.out_byte));
            end else begin
               want = pending_chars.pop_front();
               chars_checked++;
               if (rsp_ch.out_byte !== want.ch)
                  report_mismatch($sformatf("out_byte 8'h%02h, want 8'h%02h",
                                            rsp_ch.out_byte, want.ch));
               if (rsp_ch.last_of_run !== want.run_end)
                  report_mismatch($sformatf("last_of_run %b, want %b on 8'h%02h",
                                            rsp_ch.last_of_run, want.run_end, want.ch));
               if (rsp_ch.frame_end !== want.lf_end)
                  report_mismatch($sformatf("frame_end %b, want %b on 8'h%02h",
                                            rsp_ch.frame_end, want.lf_end, want.ch));
            end
         end
         rsp_ch.ready <= !reset && (steady_flow || $urandom_range(99) >= IDLE_PCT);
      end
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #400000;
      $display("timeout with %0d characters outstanding", pending_chars.size());
      $display("status: fail");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/xcsf_pkg.sv
hw/rtl/xcsf_req_if.sv
hw/rtl/xcsf_rsp_if.sv
hw/rtl/xcsf_calc.sv
hw/rtl/xcsf_emit.sv
hw/rtl/xor_checksum_sentence_framer.sv
tb/testbench.sv
